[design/mma_pkg.sv]
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants for the matrix multiply-accumulate
// Widths, command and state encodings, and small helpers used across files.
// ----------------------------------------------------------------------------
package mma_pkg;

    // Largest matrix side held in the element stores
    localparam int unsigned MAX_DIM     = 8;
    localparam int unsigned IDX_W       = $clog2(MAX_DIM);
    localparam int unsigned ADDR_W      = $clog2(MAX_DIM * MAX_DIM);
    localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;

    // Fixed field widths
    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned POS_W     = 3;
    localparam int unsigned VAL_W     = 40;
    localparam int unsigned AB_W      = 16;
    localparam int unsigned PROD_W    = 2 * AB_W;
    localparam int unsigned ACC_W     = VAL_W + 4;
    localparam int unsigned CFG_W     = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_RESET = 8;

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_LOAD_C  = 2'd2,
        FUNC_COMPUTE = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_OF_A  = 2'd0,
        CFG_INNER_DIM  = 2'd1,
        CFG_COLS_OF_B  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ISSUE,
        BK_DRAIN,
        BK_EMIT
    } t_back_state;

    // One classified item as it sits in the queue
    typedef struct packed {
        t_func                    op;
        logic [ADDR_W-1:0]        addr;
        logic signed [VAL_W-1:0]  value;
    } t_cmd;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    // Clamped dimensions, each held as (dimension - 1)
    typedef struct packed {
        logic [IDX_W-1:0] m_last;
        logic [IDX_W-1:0] n_last;
        logic [IDX_W-1:0] p_last;
    } t_dims;

    // Zero reads as 1, anything above MAX_DIM reads as MAX_DIM
    function automatic logic [IDX_W-1:0] dim_last(input logic [CFG_W-1:0] r);
        logic [CFG_W-1:0] rm1;
        rm1 = r - CFG_W'(1);
        if (r == '0)
            return '0;
        else if (r > CFG_W'(MAX_DIM))
            return IDX_W'(MAX_DIM - 1);
        else
            return rm1[IDX_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [POS_W-1:0] row,
                                                  input logic [POS_W-1:0] col);
        return ADDR_W'(row * MAX_DIM + col);
    endfunction

endpackage

[design/mma_if.sv]
// ----------------------------------------------------------------------------
// mma_if: channel interfaces for the matrix multiply-accumulate
// Input item channel, result item channel and register write channel.
// ----------------------------------------------------------------------------
interface mma_in_if;
    logic                                valid;
    logic                                ready;
    logic [mma_pkg::FUNC_W-1:0]          func;
    logic [mma_pkg::POS_W-1:0]           row_index;
    logic [mma_pkg::POS_W-1:0]           col_index;
    logic signed [mma_pkg::VAL_W-1:0]    element_value;

    modport source (output valid, func, row_index, col_index, element_value,
                    input ready);
    modport sink   (input valid, func, row_index, col_index, element_value,
                    output ready);
endinterface

interface mma_out_if;
    logic                                valid;
    logic                                ready;
    logic [mma_pkg::POS_W-1:0]           out_row;
    logic [mma_pkg::POS_W-1:0]           out_col;
    logic signed [mma_pkg::VAL_W-1:0]    out_value;
    logic                                last_element;

    modport source (output valid, out_row, out_col, out_value, last_element,
                    input ready);
    modport sink   (input valid, out_row, out_col, out_value, last_element,
                    output ready);
endinterface

interface mma_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mma_pkg::CFG_IDX_W-1:0]       index;
    logic [mma_pkg::CFG_W-1:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/mma_queue.sv]
// ----------------------------------------------------------------------------
// mma_queue: command queue between front and back end
// Small FIFO of classified items; lets either side stall on its own.
// ----------------------------------------------------------------------------
module mma_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mma_pkg::t_cmd     i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output mma_pkg::t_qhead   o_head
);

    mma_pkg::t_cmd                  r_slot [mma_pkg::QUEUE_DEPTH];
    logic [mma_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [mma_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [mma_pkg::QCNT_W-1:0]     r_count,  n_count;
    logic                           do_push, do_pop;

    assign o_full       = (r_count == mma_pkg::QCNT_W'(mma_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_slot[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == mma_pkg::QPTR_W'(mma_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + mma_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == mma_pkg::QPTR_W'(mma_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + mma_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
            n_count = r_count + mma_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            n_count = r_count - mma_pkg::QCNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_slot[r_wr_ptr] <= i_cmd;
    end

endmodule

[design/mma_front.sv]
// ----------------------------------------------------------------------------
// mma_front: item intake and classification
// Holds the dimension registers, saturates A/B values, forms store addresses.
// ----------------------------------------------------------------------------
module mma_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mma_in_if.sink          i_in,
    mma_cfg_if.sink         i_cfg,
    output logic            o_push,
    output mma_pkg::t_cmd   o_cmd,
    input  logic            i_q_full,
    output mma_pkg::t_dims  o_dims
);

    logic [mma_pkg::CFG_W-1:0]        r_rows, r_inner, r_cols;
    logic                             accept, in_range;
    logic signed [mma_pkg::AB_W-1:0]  ab_sat;
    mma_pkg::t_func                   func;

    // ---- dimension registers ----
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= mma_pkg::CFG_W'(mma_pkg::CFG_RESET);
            r_inner <= mma_pkg::CFG_W'(mma_pkg::CFG_RESET);
            r_cols  <= mma_pkg::CFG_W'(mma_pkg::CFG_RESET);
        end else if (i_cfg.valid) begin
            case (mma_pkg::t_cfg_idx'(i_cfg.index))
                mma_pkg::CFG_ROWS_OF_A: r_rows  <= i_cfg.data;
                mma_pkg::CFG_INNER_DIM: r_inner <= i_cfg.data;
                mma_pkg::CFG_COLS_OF_B: r_cols  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_dims.m_last = mma_pkg::dim_last(r_rows);
    assign o_dims.n_last = mma_pkg::dim_last(r_inner);
    assign o_dims.p_last = mma_pkg::dim_last(r_cols);

    // ---- classification ----
    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign func       = mma_pkg::t_func'(i_in.func);

    // loads outside the store are dropped
    assign in_range = ({1'b0, i_in.row_index} < (mma_pkg::POS_W + 1)'(mma_pkg::MAX_DIM)) &&
                      ({1'b0, i_in.col_index} < (mma_pkg::POS_W + 1)'(mma_pkg::MAX_DIM));

    always_comb begin
        if (i_in.element_value > 40'sd32767)
            ab_sat = 16'sh7FFF;
        else if (i_in.element_value < -40'sd32768)
            ab_sat = 16'sh8000;
        else
            ab_sat = i_in.element_value[mma_pkg::AB_W-1:0];
    end

    always_comb begin
        o_cmd.op    = func;
        o_cmd.addr  = mma_pkg::addr_of(i_in.row_index, i_in.col_index);
        o_cmd.value = i_in.element_value;
        if (func == mma_pkg::FUNC_LOAD_A || func == mma_pkg::FUNC_LOAD_B)
            o_cmd.value = {{(mma_pkg::VAL_W - mma_pkg::AB_W){ab_sat[mma_pkg::AB_W-1]}},
                           ab_sat};
        o_push = accept && (in_range || func == mma_pkg::FUNC_COMPUTE);
    end

endmodule

[design/mma_back.sv]
// ----------------------------------------------------------------------------
// mma_back: element stores and multiply-accumulate sequencer
// Performs loads, then walks C in row-major order with a pipelined dot product.
// ----------------------------------------------------------------------------
module mma_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mma_pkg::t_qhead  i_head,
    output logic             o_pop,
    input  mma_pkg::t_dims   i_dims,
    mma_out_if.source        o_out
);

    localparam int unsigned EXT_W = mma_pkg::ACC_W - mma_pkg::VAL_W;

    // stores
    logic [mma_pkg::AB_W-1:0]         r_a_mem [mma_pkg::STORE_DEPTH];
    logic [mma_pkg::AB_W-1:0]         r_b_mem [mma_pkg::STORE_DEPTH];
    logic [mma_pkg::VAL_W-1:0]        r_c_mem [mma_pkg::STORE_DEPTH];
    logic [mma_pkg::STORE_DEPTH-1:0]  r_c_vld;

    // sequencer
    mma_pkg::t_back_state             r_state, n_state;
    logic [mma_pkg::IDX_W-1:0]        r_i, n_i, r_j, n_j, r_k, n_k;
    logic                             issue, emit;
    logic                             a_we, b_we, c_we;
    logic [mma_pkg::ADDR_W-1:0]       a_raddr, b_raddr, c_raddr, c_waddr;
    logic [mma_pkg::VAL_W-1:0]        c_wdata;

    // datapath
    logic signed [mma_pkg::AB_W-1:0]   r_a_q, r_b_q;
    logic signed [mma_pkg::VAL_W-1:0]  r_c_q, r_c_init;
    logic                              r_cv_q;
    logic                              r_s1_vld, r_s1_first, r_s1_last;
    logic                              r_s2_vld, r_s2_first, r_s2_last;
    logic signed [mma_pkg::PROD_W-1:0] r_prod;
    logic signed [mma_pkg::ACC_W-1:0]  r_acc, acc_base, prod_ext;
    logic                              r_acc_done;
    logic signed [mma_pkg::VAL_W-1:0]  acc_sat;

    // output register
    logic                              r_out_vld;
    logic [mma_pkg::POS_W-1:0]         r_out_row, r_out_col;
    logic signed [mma_pkg::VAL_W-1:0]  r_out_val;
    logic                              r_out_last;

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        o_pop   = 1'b0;
        issue   = 1'b0;
        emit    = 1'b0;
        case (r_state)
            mma_pkg::BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (i_head.cmd.op == mma_pkg::FUNC_COMPUTE) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_state = mma_pkg::BK_ISSUE;
                    end
                end
            end
            mma_pkg::BK_ISSUE: begin
                issue = 1'b1;
                if (r_k == i_dims.n_last) begin
                    n_k     = '0;
                    n_state = mma_pkg::BK_DRAIN;
                end else begin
                    n_k = r_k + mma_pkg::IDX_W'(1);
                end
            end
            mma_pkg::BK_DRAIN: begin
                if (r_acc_done)
                    n_state = mma_pkg::BK_EMIT;
            end
            mma_pkg::BK_EMIT: begin
                if (!r_out_vld || o_out.ready) begin
                    emit    = 1'b1;
                    n_state = mma_pkg::BK_ISSUE;
                    if (r_j == i_dims.p_last) begin
                        n_j = '0;
                        if (r_i == i_dims.m_last)
                            n_state = mma_pkg::BK_IDLE;
                        else
                            n_i = r_i + mma_pkg::IDX_W'(1);
                    end else begin
                        n_j = r_j + mma_pkg::IDX_W'(1);
                    end
                end
            end
            default: n_state = mma_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mma_pkg::BK_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // ---- store ports ----
    assign a_we = o_pop && (i_head.cmd.op == mma_pkg::FUNC_LOAD_A);
    assign b_we = o_pop && (i_head.cmd.op == mma_pkg::FUNC_LOAD_B);
    assign c_we = (o_pop && (i_head.cmd.op == mma_pkg::FUNC_LOAD_C)) || emit;

    assign c_waddr = emit ? c_raddr : i_head.cmd.addr;
    assign c_wdata = emit ? acc_sat : i_head.cmd.value;

    assign a_raddr = mma_pkg::addr_of(mma_pkg::POS_W'(r_i), mma_pkg::POS_W'(r_k));
    assign b_raddr = mma_pkg::addr_of(mma_pkg::POS_W'(r_k), mma_pkg::POS_W'(r_j));
    assign c_raddr = mma_pkg::addr_of(mma_pkg::POS_W'(r_i), mma_pkg::POS_W'(r_j));

    always_ff @(posedge i_clk) begin
        if (a_we)
            r_a_mem[i_head.cmd.addr] <= i_head.cmd.value[mma_pkg::AB_W-1:0];
        r_a_q <= r_a_mem[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we)
            r_b_mem[i_head.cmd.addr] <= i_head.cmd.value[mma_pkg::AB_W-1:0];
        r_b_q <= r_b_mem[b_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (c_we)
            r_c_mem[c_waddr] <= c_wdata;
        r_c_q <= r_c_mem[c_raddr];
    end

    // C reads as zero until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= '0;
        end else if (c_we) begin
            r_c_vld[c_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cv_q <= r_c_vld[c_raddr];
    end

    // ---- dot-product pipeline: read, multiply, accumulate ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            if (r_s2_vld && r_s2_last)
                r_acc_done <= 1'b1;
            else if (r_state == mma_pkg::BK_DRAIN)
                r_acc_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_first <= (r_k == '0);
        r_s1_last  <= (r_k == i_dims.n_last);
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_prod     <= r_a_q * r_b_q;
        r_c_init   <= r_cv_q ? r_c_q : '0;
        if (r_s2_vld)
            r_acc <= acc_base + prod_ext;
    end

    assign acc_base = r_s2_first ? {{EXT_W{r_c_init[mma_pkg::VAL_W-1]}}, r_c_init} : r_acc;
    assign prod_ext = {{(mma_pkg::ACC_W - mma_pkg::PROD_W){r_prod[mma_pkg::PROD_W-1]}},
                       r_prod};

    // saturate to 40 bits: top bits must all match the 40-bit sign
    always_comb begin
        if (r_acc[mma_pkg::ACC_W-1:mma_pkg::VAL_W-1] == '0 ||
            r_acc[mma_pkg::ACC_W-1:mma_pkg::VAL_W-1] == '1)
            acc_sat = r_acc[mma_pkg::VAL_W-1:0];
        else if (r_acc[mma_pkg::ACC_W-1])
            acc_sat = {1'b1, {(mma_pkg::VAL_W-1){1'b0}}};
        else
            acc_sat = {1'b0, {(mma_pkg::VAL_W-1){1'b1}}};
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_row  <= mma_pkg::POS_W'(r_i);
            r_out_col  <= mma_pkg::POS_W'(r_j);
            r_out_val  <= acc_sat;
            r_out_last <= (r_i == i_dims.m_last) && (r_j == i_dims.p_last);
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.out_row      = r_out_row;
    assign o_out.out_col      = r_out_col;
    assign o_out.out_value    = r_out_val;
    assign o_out.last_element = r_out_last;

endmodule

[design/matrix_multiply_accumulate.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate: dense C += A * B over 8x8 element stores
// Front end classifies items into a queue; back end loads stores and computes.
// ----------------------------------------------------------------------------
//
//  channel  | dir | fields                                      | takes when
//  ---------+-----+---------------------------------------------+-----------------
//  i_in     | in  | func, row_index, col_index, element_value   | valid & ready
//  o_out    | out | out_row, out_col, out_value, last_element   | valid & ready
//  i_cfg    | in  | index (0 rows, 1 inner, 2 cols), data       | valid (ready = 1)
//
//  Loads: one item a cycle while the four-entry queue is not full; the back end
//  writes the A, B or C store in the cycle it pops the item.
//  Compute: for each C element the sequencer issues N store reads (one A/B read
//  port each), waits for the multiply/accumulate pipeline to drain, then writes
//  back and emits the element.
//  Reset is synchronous; the C store reads as zero through per-entry valid bits,
//  so no clearing pass is needed.
//  A stalled result stalls the sequencer only; loads keep filling the queue.
//
module matrix_multiply_accumulate (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mma_in_if.sink    i_in,
    mma_out_if.source o_out,
    mma_cfg_if.sink   i_cfg
);

    mma_pkg::t_cmd    q_cmd;      // classified item into the queue
    mma_pkg::t_qhead  q_head;     // queue head to the back end
    mma_pkg::t_dims   dims;       // clamped dimensions
    logic             q_push;
    logic             q_full;
    logic             q_pop;

    // intake: dimension registers, saturation, addressing
    mma_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .o_push   (q_push),
        .o_cmd    (q_cmd),
        .i_q_full (q_full),
        .o_dims   (dims)
    );

    // decouples intake from the compute sequencer
    mma_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // stores, sequencer, MAC pipeline and result register
    mma_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .i_dims  (dims),
        .o_out   (o_out)
    );

endmodule

[design/mma_checker.sv]
// ----------------------------------------------------------------------------
// mma_checker: port-level checks for the matrix multiply-accumulate
// Tracks the row and column registers and checks reset, result positions and the stall.
// ----------------------------------------------------------------------------
module mma_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [mma_pkg::POS_W-1:0]         i_out_row,
    input logic [mma_pkg::POS_W-1:0]         i_out_col,
    input logic [mma_pkg::VAL_W-1:0]         i_out_value,
    input logic                              i_out_last,
    input logic                              i_cfg_valid,
    input logic                              i_cfg_ready,
    input logic [mma_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input logic [mma_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [mma_pkg::CFG_W-1:0]  r_rows, r_cols;
    logic [mma_pkg::POS_W-1:0]  m_last, p_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= mma_pkg::CFG_W'(mma_pkg::CFG_RESET);
            r_cols <= mma_pkg::CFG_W'(mma_pkg::CFG_RESET);
        end else if (i_cfg_valid && i_cfg_ready) begin
            if (i_cfg_index == mma_pkg::CFG_ROWS_OF_A)
                r_rows <= i_cfg_data;
            if (i_cfg_index == mma_pkg::CFG_COLS_OF_B)
                r_cols <= i_cfg_data;
        end
    end

    assign m_last = mma_pkg::POS_W'(mma_pkg::dim_last(r_rows));
    assign p_last = mma_pkg::POS_W'(mma_pkg::dim_last(r_cols));

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_row) &&
        $stable(i_out_col) && $stable(i_out_value) && $stable(i_out_last))
        else $error("stalled result changed");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_row <= m_last && i_out_col <= p_last)
        else $error("result position outside C");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_row == m_last && i_out_col == p_last)
        else $error("last mark on wrong element");

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_row   (o_out.out_row),
    .i_out_col   (o_out.out_col),
    .i_out_value (o_out.out_value),
    .i_out_last  (o_out.last_element),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready),
    .i_cfg_index (i_cfg.index),
    .i_cfg_data  (i_cfg.data)
);
